// ===== rtl/fdrc_pkg.sv =====
package fdrc_pkg;

   localparam logic [2:0] FUNC_TICK  = 3'd0;
   localparam logic [2:0] FUNC_PIXEL = 3'd1;
   localparam logic [2:0] FUNC_FILL  = 3'd2;
   localparam logic [2:0] FUNC_DIFF  = 3'd3;
   localparam logic [2:0] FUNC_FORCE = 3'd4;

   localparam logic [1:0] REG_FLIP_TIME   = 2'd0;
   localparam logic [1:0] REG_DIRECT_MODE = 2'd1;
   localparam logic [1:0] REG_PANEL_WIDTH = 2'd2;

   localparam int PIN_BITS   = 17;
   localparam int PIN_ENABLE = 16;

   typedef enum logic [2:0] {
      CMD_TICK,
      CMD_PIXEL,
      CMD_FILL,
      CMD_DIFF,
      CMD_FORCE
   } cmd_type;

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_DIFF,
      MODE_FORCE,
      MODE_FILL
   } mode_type;

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_READ,
      ST_DIV,
      ST_EMIT
   } state_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] x;
      logic [4:0] y;
      logic       color;
      logic       in_range;
   } item_type;

   typedef struct packed {
      logic [15:0] flip_time;
      logic        direct_mode;
      logic [4:0]  panel_width;
   } cfg_type;

endpackage

// ===== rtl/fdrc_ram.sv =====
module fdrc_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2048,
   parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ===== rtl/fdrc_div.sv =====
module fdrc_div
   import fdrc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [7:0] dividend,
   input  logic [4:0] divisor,
   output logic       done,
   output logic [7:0] quot,
   output logic [4:0] rem
);

   logic       busy_ff, busy_in;
   logic       done_ff, done_in;
   logic [2:0] cnt_ff, cnt_in;
   logic [7:0] quot_ff, quot_in;
   logic [4:0] rem_ff, rem_in;
   logic [4:0] div_ff, div_in;
   logic [5:0] trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      trial   = {rem_ff, quot_ff[7]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 3'd0;
         quot_in = dividend;
         rem_in  = 5'd0;
         div_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in  = 5'(trial - {1'b0, div_ff});
            quot_in = {quot_ff[6:0], 1'b1};
         end else begin
            rem_in  = trial[4:0];
            quot_in = {quot_ff[6:0], 1'b0};
         end
         cnt_in = cnt_ff + 3'd1;
         if (cnt_ff == 3'd7) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;
   assign rem  = rem_ff;

endmodule

// ===== rtl/fdrc_front.sv =====
module fdrc_front
   import fdrc_pkg::*;
#(
   parameter int COLUMNS = 128,
   parameter int ROWS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_func,
   input  logic [7:0] req_x,
   input  logic [4:0] req_y,
   input  logic       req_color,
   output logic       q_valid,
   output item_type   q_item,
   input  logic       q_pop
);

   item_type   q_ff [2];
   item_type   q_in [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   item_type   item;
   logic       push;

   always_comb begin
      case (req_func)
         FUNC_TICK:  item.cmd = CMD_TICK;
         FUNC_PIXEL: item.cmd = CMD_PIXEL;
         FUNC_FILL:  item.cmd = CMD_FILL;
         FUNC_DIFF:  item.cmd = CMD_DIFF;
         FUNC_FORCE: item.cmd = CMD_FORCE;
         default:    item.cmd = CMD_TICK;
      endcase
      item.x        = req_x;
      item.y        = req_y;
      item.color    = req_color;
      item.in_range = (int'(req_x) < COLUMNS) && (int'(req_y) < ROWS);
   end

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = q_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      q_ff[0] <= q_in[0];
      q_ff[1] <= q_in[1];
   end

   always_comb begin
      q_in[0]   = q_ff[0];
      q_in[1]   = q_ff[1];
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         q_in[wr_ptr_ff] = item;
         wr_ptr_in       = ~wr_ptr_ff;
      end
      if (q_pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

endmodule

// ===== rtl/fdrc_back.sv =====
module fdrc_back
   import fdrc_pkg::*;
#(
   parameter int COLUMNS = 128,
   parameter int ROWS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                q_valid,
   input  item_type            q_item,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [PIN_BITS-1:0] rsp_pins,
   output logic                rsp_busy
);

   localparam int DOTS = COLUMNS * ROWS;
   localparam int AW = (DOTS > 1) ? $clog2(DOTS) : 1;
   localparam int CW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;

   function automatic logic [2:0] div7(input logic [4:0] v);
      div7 = {2'b0, v >= 5'd7} + {2'b0, v >= 5'd14} + {2'b0, v >= 5'd21}
           + {2'b0, v >= 5'd28};
   endfunction

   state_type           state_ff, state_in;
   mode_type            mode_ff, mode_in;
   logic [CW-1:0]       col_ff, col_in;
   logic [RW-1:0]       row_ff, row_in;
   logic                fill_ff, fill_in;
   logic [15:0]         strobe_ff, strobe_in;
   logic [PIN_BITS-1:0] pins_ff, pins_in;
   logic [AW-1:0]       cnt_ff, cnt_in;
   logic                sw_both_ff, sw_both_in;
   logic                sw_val_ff, sw_val_in;
   logic                sw_emit_ff, sw_emit_in;
   logic                is_scan_ff, is_scan_in;
   logic                color_ff, color_in;
   logic [AW-1:0]       addr_ff, addr_in;
   logic [7:0]          dot_x_ff, dot_x_in;
   logic [4:0]          dot_y_ff, dot_y_in;
   logic                dot_d_ff, dot_d_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [PIN_BITS-1:0] rsp_pins_ff, rsp_pins_in;
   logic                rsp_busy_ff, rsp_busy_in;

   logic          rd_new, rd_shown;
   logic [AW-1:0] rd_addr, wr_addr;
   logic          new_we, new_wd, shown_we, shown_wd;
   logic          div_start, div_done;
   logic [7:0]    div_quot;
   logic [4:0]    div_rem, divisor, colc, rowc;
   logic          go, drive;

   fdrc_ram #(.WIDTH(1), .DEPTH(DOTS), .AW(AW)) u_new_ram (
      .clock(clock), .wr_en(new_we), .wr_addr(wr_addr), .wr_data(new_wd),
      .rd_addr(rd_addr), .rd_data(rd_new)
   );

   fdrc_ram #(.WIDTH(1), .DEPTH(DOTS), .AW(AW)) u_shown_ram (
      .clock(clock), .wr_en(shown_we), .wr_addr(wr_addr), .wr_data(shown_wd),
      .rd_addr(rd_addr), .rd_data(rd_shown)
   );

   assign divisor = (cfg.panel_width == 5'd0) ? 5'd1 : cfg.panel_width;

   fdrc_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(dot_x_in),
      .divisor(divisor), .done(div_done), .quot(div_quot), .rem(div_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         mode_ff      <= MODE_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         fill_ff      <= 1'b0;
         strobe_ff    <= 16'd0;
         pins_ff      <= '1;
         cnt_ff       <= '0;
         sw_both_ff   <= 1'b1;
         sw_val_ff    <= 1'b0;
         sw_emit_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         fill_ff      <= fill_in;
         strobe_ff    <= strobe_in;
         pins_ff      <= pins_in;
         cnt_ff       <= cnt_in;
         sw_both_ff   <= sw_both_in;
         sw_val_ff    <= sw_val_in;
         sw_emit_ff   <= sw_emit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      is_scan_ff  <= is_scan_in;
      color_ff    <= color_in;
      addr_ff     <= addr_in;
      dot_x_ff    <= dot_x_in;
      dot_y_ff    <= dot_y_in;
      dot_d_ff    <= dot_d_in;
      rsp_pins_ff <= rsp_pins_in;
      rsp_busy_ff <= rsp_busy_in;
   end

   assign colc = 5'(div_rem + 5'd1 + 5'(div7(div_rem)));
   assign rowc = 5'(dot_y_ff + 5'(div7(dot_y_ff)));

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      fill_in      = fill_ff;
      strobe_in    = strobe_ff;
      pins_in      = pins_ff;
      cnt_in       = cnt_ff;
      sw_both_in   = sw_both_ff;
      sw_val_in    = sw_val_ff;
      sw_emit_in   = sw_emit_ff;
      is_scan_in   = is_scan_ff;
      color_in     = color_ff;
      addr_in      = addr_ff;
      dot_x_in     = dot_x_ff;
      dot_y_in     = dot_y_ff;
      dot_d_in     = dot_d_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_pins_in  = rsp_pins_ff;
      rsp_busy_in  = rsp_busy_ff;
      rd_addr      = AW'(int'(row_ff) * COLUMNS + int'(col_ff));
      wr_addr      = addr_ff;
      new_we       = 1'b0;
      new_wd       = color_ff;
      shown_we     = 1'b0;
      shown_wd     = color_ff;
      div_start    = 1'b0;
      drive        = 1'b0;
      go           = 1'b0;
      q_pop        = 1'b0;

      case (state_ff)
         ST_SWEEP: begin
            wr_addr  = cnt_ff;
            new_we   = 1'b1;
            new_wd   = sw_val_ff;
            shown_we = sw_both_ff;
            shown_wd = sw_val_ff;
            cnt_in   = cnt_ff + AW'(1);
            if (int'(cnt_ff) == DOTS - 1) begin
               cnt_in   = '0;
               state_in = sw_emit_ff ? ST_EMIT : ST_IDLE;
            end
         end
         ST_IDLE: begin
            go    = q_valid && !rsp_valid_ff;
            q_pop = go;
            if (go) begin
               state_in = ST_EMIT;
               if (strobe_ff != 16'd0) begin
                  strobe_in = strobe_ff - 16'd1;
                  if (strobe_ff == 16'd1) begin
                     pins_in[PIN_ENABLE] = 1'b1;
                  end
               end else if (mode_ff != MODE_IDLE) begin
                  addr_in    = rd_addr;
                  is_scan_in = 1'b1;
                  state_in   = ST_READ;
               end else begin
                  case (q_item.cmd)
                     CMD_PIXEL: begin
                        if (q_item.in_range) begin
                           rd_addr = AW'(int'(q_item.y) * COLUMNS + int'(q_item.x));
                           addr_in    = rd_addr;
                           is_scan_in = 1'b0;
                           color_in   = q_item.color;
                           dot_x_in   = q_item.x;
                           dot_y_in   = q_item.y;
                           state_in   = ST_READ;
                        end
                     end
                     CMD_FILL: begin
                        sw_val_in  = q_item.color;
                        sw_both_in = cfg.direct_mode;
                        sw_emit_in = 1'b1;
                        cnt_in     = '0;
                        state_in   = ST_SWEEP;
                        if (cfg.direct_mode) begin
                           fill_in = q_item.color;
                           mode_in = MODE_FILL;
                           col_in  = '0;
                           row_in  = '0;
                        end
                     end
                     CMD_DIFF, CMD_FORCE: begin
                        if (!cfg.direct_mode) begin
                           mode_in = (q_item.cmd == CMD_FORCE) ? MODE_FORCE : MODE_DIFF;
                           col_in  = '0;
                           row_in  = '0;
                        end
                     end
                     default: begin
                        state_in = ST_EMIT;
                     end
                  endcase
               end
            end
         end
         ST_READ: begin
            if (is_scan_ff) begin
               dot_x_in = 8'(col_ff);
               dot_y_in = 5'(row_ff);
               if (mode_ff == MODE_FILL) begin
                  drive    = 1'b1;
                  dot_d_in = fill_ff;
               end else begin
                  shown_we = 1'b1;
                  shown_wd = rd_new;
                  dot_d_in = rd_new;
                  drive    = (mode_ff == MODE_FORCE) || (rd_new != rd_shown);
               end
               if (int'(row_ff) == ROWS - 1) begin
                  row_in = '0;
                  if (int'(col_ff) == COLUMNS - 1) begin
                     col_in  = '0;
                     mode_in = MODE_IDLE;
                  end else begin
                     col_in = col_ff + CW'(1);
                  end
               end else begin
                  row_in = row_ff + RW'(1);
               end
            end else if (rd_new != color_ff) begin
               new_we   = 1'b1;
               shown_we = cfg.direct_mode;
               drive    = cfg.direct_mode;
               dot_d_in = color_ff;
            end
            div_start = drive;
            state_in  = drive ? ST_DIV : ST_EMIT;
         end
         ST_DIV: begin
            if (div_done) begin
               pins_in   = {1'b0, ~dot_d_ff, dot_d_ff, ~dot_d_ff, rowc, colc,
                            div_quot[2:0]};
               strobe_in = (cfg.flip_time == 16'd0) ? 16'd1 : cfg.flip_time;
               state_in  = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_pins_in  = pins_ff;
            rsp_busy_in  = (mode_ff != MODE_IDLE) || (strobe_ff != 16'd0);
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pins  = rsp_pins_ff;
   assign rsp_busy  = rsp_busy_ff;

endmodule

// ===== rtl/flip_dot_refresh_controller.sv =====
// Flip-dot panel controller with a new-frame store and a shown-frame store.
// Each beat on the req_ channel is one tick or command (tick, set pixel,
// fill, refresh changed dots, forced refresh); each beat yields exactly one
// beat on the rsp_ channel carrying the panel pin levels and the busy flag.
// While a scan, fill or strobe is in progress every beat acts as a tick.
// A two-entry queue sits between the accepting front end and the sequencer,
// so requests are taken while a result waits for rsp_ready.
// A tick or plain command passes from the queue through the sequencer's emit
// state into the result register; the sequencer takes a new beat only when it
// is idle and the last result has been taken. A beat that reads a frame store
// also passes a read state, and one that flips a dot waits for the serial column
// divider. A fill sweeps the frame stores, one dot per cycle. After reset both
// stores are swept to zero, during which no result is produced; configuration
// writes on the csr_ port are taken at any time. When the receiver holds
// rsp_ready low the sequencer stops and at most two further requests queue.
module flip_dot_refresh_controller
   import fdrc_pkg::*;
#(
   parameter int COLUMNS = 128,
   parameter int ROWS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_func,
   input  logic [7:0]  req_x,
   input  logic [4:0]  req_y,
   input  logic        req_color,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_panel_addr,
   output logic [4:0]  rsp_col_code,
   output logic [4:0]  rsp_row_code,
   output logic        rsp_row_set,
   output logic        rsp_row_clear,
   output logic        rsp_col_level,
   output logic        rsp_enable_n,
   output logic        rsp_busy_res,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type             cfg_ff, cfg_in;
   logic                q_valid, q_pop;
   item_type            q_item;
   logic [PIN_BITS-1:0] pins;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.flip_time   <= 16'd500;
         cfg_ff.direct_mode <= 1'b0;
         cfg_ff.panel_width <= 5'd28;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_paddr[3:2])
            REG_FLIP_TIME:   cfg_in.flip_time   = csr_pwdata[15:0];
            REG_DIRECT_MODE: cfg_in.direct_mode = csr_pwdata[0];
            REG_PANEL_WIDTH: cfg_in.panel_width = csr_pwdata[4:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
      case (csr_paddr[3:2])
         REG_FLIP_TIME:   csr_prdata = {16'd0, cfg_ff.flip_time};
         REG_DIRECT_MODE: csr_prdata = {31'd0, cfg_ff.direct_mode};
         REG_PANEL_WIDTH: csr_prdata = {27'd0, cfg_ff.panel_width};
         default:         csr_prdata = 32'd0;
      endcase
   end

   assign csr_pready = 1'b1;

   fdrc_front #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_func(req_func),
      .req_x(req_x), .req_y(req_y), .req_color(req_color),
      .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
   );

   fdrc_back #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_pins(pins), .rsp_busy(rsp_busy_res)
   );

   assign rsp_panel_addr = pins[2:0];
   assign rsp_col_code   = pins[7:3];
   assign rsp_row_code   = pins[12:8];
   assign rsp_row_set    = pins[13];
   assign rsp_row_clear  = pins[14];
   assign rsp_col_level  = pins[15];
   assign rsp_enable_n   = pins[16];

endmodule

// ===== tb/tb_top.sv =====
module tb_top
   import fdrc_pkg::*;
();

   localparam int COLS        = 128;
   localparam int ROWS        = 16;
   localparam int DOTS        = COLS * ROWS;
   localparam int STALL_MAX   = 20000;
   localparam int SETTLE      = 40;
   localparam int RAND_ITEMS  = 420;
   localparam int FINAL_ITEMS = 80;

   typedef struct packed {
      logic [2:0] panel_addr;
      logic [4:0] col_code;
      logic [4:0] row_code;
      logic       row_set;
      logic       row_clear;
      logic       col_level;
      logic       enable_n;
      logic       busy_res;
   } pins_type;

   class dot_scoreboard;
      logic [15:0] flip_time;
      logic        direct_mode;
      logic [4:0]  panel_width;
      bit          new_frame[DOTS];
      bit          shown_frame[DOTS];
      int          scan_col;
      int          scan_row;
      mode_type    scan_mode;
      bit          fill_value;
      int          strobe_left;
      pins_type    pins;
      pins_type    pending_pins[$];
      int          errors;

      function void clear();
         flip_time = 16'd500;
         direct_mode = 1'b0;
         panel_width = 5'd28;
         foreach (new_frame[i]) begin
            new_frame[i] = 1'b0;
            shown_frame[i] = 1'b0;
         end
         scan_col = 0;
         scan_row = 0;
         scan_mode = MODE_IDLE;
         fill_value = 1'b0;
         strobe_left = 0;
         pins = '1;
         errors = 0;
      endfunction

      function bit busy();
         return scan_mode != MODE_IDLE || strobe_left > 0;
      endfunction

      function void drive_dot(int x, int y, bit d);
         int pw;
         int c;
         pw = (panel_width == 0) ? 1 : int'(panel_width);
         c = x % pw;
         pins.panel_addr = 3'(x / pw);
         pins.col_code = 5'(c + 1 + c / 7);
         pins.row_code = 5'(y + y / 7);
         pins.row_set = !d;
         pins.row_clear = d;
         pins.col_level = !d;
         pins.enable_n = 1'b0;
         strobe_left = (flip_time == 0) ? 1 : int'(flip_time);
      endfunction

      function void scan_dot();
         int idx;
         bit nv;
         idx = scan_row * COLS + scan_col;
         if (scan_mode == MODE_FILL) begin
            drive_dot(scan_col, scan_row, fill_value);
         end else begin
            nv = new_frame[idx];
            if (scan_mode == MODE_FORCE || nv != shown_frame[idx]) begin
               drive_dot(scan_col, scan_row, nv);
            end
            shown_frame[idx] = nv;
         end
         scan_row++;
         if (scan_row >= ROWS) begin
            scan_row = 0;
            scan_col++;
            if (scan_col >= COLS) begin
               scan_col = 0;
               scan_mode = MODE_IDLE;
            end
         end
      endfunction

      function void note(logic [2:0] func, logic [7:0] x, logic [4:0] y, logic color);
         int idx;
         if (strobe_left > 0) begin
            strobe_left--;
            if (strobe_left == 0) begin
               pins.enable_n = 1'b1;
            end
         end else if (scan_mode != MODE_IDLE) begin
            scan_dot();
         end else if (func == FUNC_PIXEL) begin
            if (x < COLS && y < ROWS) begin
               idx = y * COLS + x;
               if (new_frame[idx] != color) begin
                  new_frame[idx] = color;
                  if (direct_mode) begin
                     shown_frame[idx] = color;
                     drive_dot(x, y, color);
                  end
               end
            end
         end else if (func == FUNC_FILL) begin
            foreach (new_frame[i]) begin
               new_frame[i] = color;
               if (direct_mode) begin
                  shown_frame[i] = color;
               end
            end
            if (direct_mode) begin
               fill_value = color;
               scan_col = 0;
               scan_row = 0;
               scan_mode = MODE_FILL;
            end
         end else if (func == FUNC_DIFF || func == FUNC_FORCE) begin
            if (!direct_mode) begin
               scan_col = 0;
               scan_row = 0;
               scan_mode = (func == FUNC_FORCE) ? MODE_FORCE : MODE_DIFF;
            end
         end
         pins.busy_res = busy();
         pending_pins.push_back(pins);
      endfunction

      task report(string msg);
         errors++;
         $display("mismatch at %0t: %s", $realtime, msg);
      endtask

      task check(pins_type got);
         pins_type e;
         if (pending_pins.size() == 0) begin
            report("result beat with no expectation");
            return;
         end
         e = pending_pins.pop_front();
         if (got.panel_addr !== e.panel_addr)
            report($sformatf("panel_addr %0d, expected %0d", got.panel_addr, e.panel_addr));
         if (got.col_code !== e.col_code)
            report($sformatf("col_code %0d, expected %0d", got.col_code, e.col_code));
         if (got.row_code !== e.row_code)
            report($sformatf("row_code %0d, expected %0d", got.row_code, e.row_code));
         if (got.row_set !== e.row_set)
            report($sformatf("row_set %b, expected %b", got.row_set, e.row_set));
         if (got.row_clear !== e.row_clear)
            report($sformatf("row_clear %b, expected %b", got.row_clear, e.row_clear));
         if (got.col_level !== e.col_level)
            report($sformatf("col_level %b, expected %b", got.col_level, e.col_level));
         if (got.enable_n !== e.enable_n)
            report($sformatf("enable_n %b, expected %b", got.enable_n, e.enable_n));
         if (got.busy_res !== e.busy_res)
            report($sformatf("busy_res %b, expected %b", got.busy_res, e.busy_res));
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_func;
   logic [7:0]  req_x;
   logic [4:0]  req_y;
   logic        req_color;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_panel_addr;
   logic [4:0]  rsp_col_code;
   logic [4:0]  rsp_row_code;
   logic        rsp_row_set;
   logic        rsp_row_clear;
   logic        rsp_col_level;
   logic        rsp_enable_n;
   logic        rsp_busy_res;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   dot_scoreboard frame_sb;
   bit            hold_rsp;
   int            stall_cycles;

   flip_dot_refresh_controller #(.COLUMNS(COLS), .ROWS(ROWS)) dut (.*);

   initial clock = 1'b0;
   always #6 clock = ~clock;

   function int draw_idle();
      return int'($urandom_range(0, 9));
   endfunction

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_MAX) begin
         $display("flip_dot_refresh_controller regression: fail");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      pins_type got;
      int gap;
      bit held;
      held = 1'b0;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp && !held) begin
            held = 1'b1;
            gap = 400;
         end else begin
            gap = draw_idle();
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         got = {rsp_panel_addr, rsp_col_code, rsp_row_code, rsp_row_set, rsp_row_clear,
                rsp_col_level, rsp_enable_n, rsp_busy_res};
         frame_sb.check(got);
      end
   end

   task send_beat(logic [2:0] func, logic [7:0] x, logic [4:0] y, logic color);
      int gap;
      gap = draw_idle();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_x <= x;
      req_y <= y;
      req_color <= color;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      frame_sb.note(func, x, y, color);
   endtask

   task send_noise();
      logic [2:0] func;
      func = 3'($urandom_range(0, 7));
      if (!frame_sb.busy() &&
          (func == FUNC_FILL || func == FUNC_DIFF || func == FUNC_FORCE)) begin
         func = FUNC_TICK;
      end
      send_beat(func, 8'($urandom), 5'($urandom), 1'($urandom));
   endtask

   task wait_quiet();
      req_valid <= 1'b0;
      while (frame_sb.pending_pins.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task write_csr(logic [1:0] idx, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_FLIP_TIME:   frame_sb.flip_time = value[15:0];
         REG_DIRECT_MODE: frame_sb.direct_mode = value[0];
         REG_PANEL_WIDTH: frame_sb.panel_width = value[4:0];
         default: ;
      endcase
   endtask

   task configure(logic [15:0] ft, logic dm, logic [4:0] pw);
      wait_quiet();
      write_csr(REG_FLIP_TIME, {16'd0, ft});
      write_csr(REG_DIRECT_MODE, {31'd0, dm});
      write_csr(REG_PANEL_WIDTH, {27'd0, pw});
   endtask

   task random_beat();
      int pick;
      logic [2:0] func;
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
         func = (frame_sb.direct_mode || frame_sb.busy()) ? FUNC_DIFF : FUNC_TICK;
      end else if (pick < 5) begin
         func = (frame_sb.direct_mode || frame_sb.busy()) ? FUNC_FORCE : FUNC_TICK;
      end else if (pick < 9) begin
         func = (!frame_sb.direct_mode || frame_sb.busy()) ? FUNC_FILL : FUNC_TICK;
      end else if (pick < 15) begin
         func = FUNC_TICK;
      end else if (pick < 19) begin
         func = 3'($urandom_range(FUNC_FORCE + 1, 7));
      end else begin
         func = FUNC_PIXEL;
      end
      if (pick < 33) begin
         send_beat(func, 8'($urandom), 5'($urandom), 1'($urandom));
      end else begin
         send_beat(func, 8'($urandom_range(0, COLS - 1)),
                   5'($urandom_range(0, ROWS - 1)), 1'($urandom));
      end
   endtask

   initial begin
      int count;
      int f;
      frame_sb = new();
      frame_sb.clear();
      hold_rsp = 1'b0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_func <= FUNC_TICK;
      req_x <= '0;
      req_y <= '0;
      req_color <= 1'b0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_beat(FUNC_TICK, 8'd0, 5'd0, 1'b0);
      configure(16'd0, 1'b0, 5'd28);
      send_beat(FUNC_PIXEL, 8'd0, 5'd0, 1'b1);
      send_beat(FUNC_PIXEL, 8'd0, 5'd0, 1'b1);
      send_beat(FUNC_PIXEL, 8'd127, 5'd15, 1'b1);
      send_beat(FUNC_PIXEL, 8'd128, 5'd0, 1'b1);
      send_beat(FUNC_PIXEL, 8'd255, 5'd31, 1'b1);
      send_beat(FUNC_PIXEL, 8'd5, 5'd16, 1'b1);
      for (f = FUNC_FORCE + 1; f < 8; f++) send_beat(3'(f), 8'd255, 5'd31, 1'b1);
      send_beat(FUNC_FILL, 8'd0, 5'd0, 1'b0);
      send_beat(FUNC_PIXEL, 8'd70, 5'd13, 1'b1);
      send_beat(FUNC_PIXEL, 8'd127, 5'd15, 1'b1);
      configure(16'd3, 1'b1, 5'd1);
      send_beat(FUNC_PIXEL, 8'd3, 5'd9, 1'b1);
      repeat (4) send_noise();
      send_beat(FUNC_DIFF, 8'd0, 5'd0, 1'b0);
      send_beat(FUNC_FORCE, 8'd0, 5'd0, 1'b0);
      configure(16'd0, 1'b1, 5'd31);
      send_beat(FUNC_PIXEL, 8'd40, 5'd7, 1'b1);
      send_beat(FUNC_PIXEL, 8'd40, 5'd7, 1'b0);
      send_noise();
      send_noise();
      configure(16'd65535, 1'b0, 5'd0);
      send_beat(FUNC_TICK, 8'd0, 5'd0, 1'b0);
      send_beat(FUNC_PIXEL, 8'd9, 5'd2, 1'b1);
      configure(16'd5, 1'b1, 5'd7);
      send_beat(FUNC_PIXEL, 8'd100, 5'd14, 1'b1);
      hold_rsp = 1'b1;
      repeat (20) send_noise();

      count = 0;
      while (count < RAND_ITEMS) begin
         configure(16'($urandom_range(0, 2)), 1'($urandom), 5'($urandom));
         repeat (60) begin
            random_beat();
            count++;
         end
      end

      configure(16'd1, 1'b0, 5'd5);
      send_beat(FUNC_DIFF, 8'd0, 5'd0, 1'b0);
      repeat (FINAL_ITEMS) send_noise();

      wait_quiet();
      if (frame_sb.errors == 0) begin
         $display("flip_dot_refresh_controller regression: pass");
      end else begin
         $display("flip_dot_refresh_controller regression: fail");
      end
      $finish;
   end
endmodule
